// ===== sv/uimtf_pkg.sv =====
`default_nettype none
package uimtf_pkg;

   localparam int DEPTH     = 16;
   localparam int PARADIGMS = 8;

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   localparam logic [2:0] MODE_FIND  = 3'd0;
   localparam logic [2:0] MODE_PUSH  = 3'd1;
   localparam logic [2:0] MODE_POP   = 3'd2;
   localparam logic [2:0] MODE_CLEAR = 3'd3;
   localparam logic [2:0] MODE_MARK  = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef logic [PARADIGMS-1:0] flag_type;
   typedef logic [DEPTH-1:0]     match_type;

   typedef struct packed {
      logic capture;   // item accepted: latch fields and hit vector
      logic update;    // apply the operation, load the result register
   } cmd_type;

endpackage
`default_nettype wire

// ===== sv/uimtf_ctrl.sv =====
`default_nettype none
module uimtf_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output uimtf_pkg::cmd_type  cmd
);
   import uimtf_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_UPD  = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, update;

   // no item taken while reset is held
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   // result slot must be free (or draining this cycle) before we overwrite it
   assign update     = (state_ff == S_UPD) && (!rsp_valid_ff || rsp_tready);

   assign cmd.capture = accept;
   assign cmd.update  = update;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_UPD;
         S_UPD:  if (update) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/uimtf_dp.sv =====
`default_nettype none
module uimtf_dp (
   input  wire                 clock,
   input  wire                 reset,
   input  uimtf_pkg::cmd_type  cmd,
   input  wire  [2:0]          req_mode,
   input  wire  [31:0]         req_region_id,
   input  wire  [63:0]         req_enter_time,
   input  wire  [2:0]          req_paradigm_index,
   output logic [1:0]          rsp_status,
   output logic                rsp_found,
   output logic [31:0]         rsp_popped_id,
   output logic [63:0]         rsp_popped_time,
   output logic [7:0]          rsp_popped_flags,
   output logic [4:0]          rsp_entry_count
);
   import uimtf_pkg::*;

   // stack cells, bottom at index 0
   logic [31:0]        ids_ff   [DEPTH];
   logic [63:0]        times_ff [DEPTH];
   flag_type           flags_ff [DEPTH];
   logic [31:0]        ids_in   [DEPTH];
   logic [63:0]        times_in [DEPTH];
   flag_type           flags_in [DEPTH];
   logic [FILL_W-1:0]  fill_ff, fill_in;

   // latched item
   logic [2:0]         mode_ff;
   logic [31:0]        id_ff;
   logic [63:0]        time_ff;
   logic [2:0]         pidx_ff;
   match_type          match_ff, match_in;

   logic [1:0]         status_in;
   logic               found_in;
   logic [31:0]        pid_in;
   logic [63:0]        ptime_in;
   logic [7:0]         pflags_in;

   flag_type           keep;
   logic               hit;
   logic               below;
   logic [IDX_W-1:0]   top_idx;
   logic [IDX_W-1:0]   fill_idx;

   // parallel compare against live cells
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (ids_ff[i] == req_region_id) && (i < int'(fill_ff));
      end
   end

   assign top_idx  = IDX_W'(fill_ff - FILL_W'(1));
   assign fill_idx = IDX_W'(fill_ff);
   assign hit      = |match_ff;

   always_comb begin
      keep = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (match_ff[i]) keep = keep | flags_ff[i];
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ids_in[i]   = ids_ff[i];
         times_in[i] = times_ff[i];
         flags_in[i] = flags_ff[i];
      end
      fill_in   = fill_ff;
      status_in = STATUS_OK;
      found_in  = 1'b0;
      pid_in    = '0;
      ptime_in  = '0;
      pflags_in = '0;
      below     = 1'b0;
      case (mode_ff)
         MODE_FIND: found_in = hit;
         MODE_PUSH: begin
            if (hit) begin
               // close the gap above the hit, then put the id on top
               for (int i = 0; i < DEPTH - 1; i++) begin
                  below = 1'b0;
                  for (int j = 0; j <= i; j++) begin
                     below = below | match_ff[j];
                  end
                  if (below && (i + 1 < int'(fill_ff))) begin
                     ids_in[i]   = ids_ff[IDX_W'(i + 1)];
                     times_in[i] = times_ff[IDX_W'(i + 1)];
                     flags_in[i] = flags_ff[IDX_W'(i + 1)];
                  end
               end
               ids_in[top_idx]   = id_ff;
               times_in[top_idx] = time_ff;
               flags_in[top_idx] = keep;
            end else if (int'(fill_ff) >= DEPTH) begin
               status_in = STATUS_FULL;
            end else begin
               ids_in[fill_idx]   = id_ff;
               times_in[fill_idx] = time_ff;
               flags_in[fill_idx] = '0;
               fill_in            = fill_ff + FILL_W'(1);
            end
         end
         MODE_POP: begin
            if (fill_ff == '0) begin
               status_in = STATUS_EMPTY;
            end else begin
               fill_in   = fill_ff - FILL_W'(1);
               pid_in    = ids_ff[top_idx];
               ptime_in  = times_ff[top_idx];
               pflags_in = 8'(flags_ff[top_idx]);
            end
         end
         MODE_CLEAR: fill_in = '0;
         MODE_MARK: begin
            // index past the flag width shifts out to nothing
            for (int i = 0; i < DEPTH; i++) begin
               flags_in[i] = flags_ff[i] | (flag_type'(1) << pidx_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         match_ff <= '0;
      end else begin
         if (cmd.capture) match_ff <= match_in;
         if (cmd.update)  fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         id_ff   <= req_region_id;
         time_ff <= req_enter_time;
         pidx_ff <= req_paradigm_index;
      end
      if (cmd.update) begin
         for (int i = 0; i < DEPTH; i++) begin
            ids_ff[i]   <= ids_in[i];
            times_ff[i] <= times_in[i];
            flags_ff[i] <= flags_in[i];
         end
         rsp_status       <= status_in;
         rsp_found        <= found_in;
         rsp_popped_id    <= pid_in;
         rsp_popped_time  <= ptime_in;
         rsp_popped_flags <= pflags_in;
         rsp_entry_count  <= 5'(fill_in);
      end
   end

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) <= DEPTH)
      else $error("fill level beyond depth");

   a_unique_ids: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_ff))
      else $error("id present in more than one cell");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.update && (mode_ff == MODE_CLEAR) |=> (fill_ff == '0))
      else $error("clear left entries");

   a_move_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.update && (mode_ff == MODE_PUSH) && hit |=> $stable(fill_ff))
      else $error("move to top changed fill level");
`endif

endmodule
`default_nettype wire

// ===== sv/unique_id_move_to_front_stack_top.sv =====
// The hit compare is registered when the item is accepted; the stack update and result
// register load follow once the previous result has been taken or is draining, and the
// result is then valid.
// The controller alternates accept and update, so no new item is taken until the last
// is applied; an update waits while the previous result is still held.
// Reset (synchronous): stack empty, no result pending; cell contents are not cleared.
`default_nettype none
module unique_id_move_to_front_stack_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [103:0] req_tdata,   // region_id[31:0], enter_time[95:32],
                                     // paradigm_index[98:96], zero pad
   input  wire  [2:0]   req_tuser,   // mode
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [111:0] rsp_tdata    // status[1:0], found[2], popped_id[34:3],
                                     // popped_time[98:35], popped_flags[106:99],
                                     // entry_count[111:107]
);
   import uimtf_pkg::*;

   cmd_type     cmd;
   logic [1:0]  status;
   logic        found;
   logic [31:0] popped_id;
   logic [63:0] popped_time;
   logic [7:0]  popped_flags;
   logic [4:0]  entry_count;

   uimtf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   uimtf_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_mode           (req_tuser),
      .req_region_id      (req_tdata[31:0]),
      .req_enter_time     (req_tdata[95:32]),
      .req_paradigm_index (req_tdata[98:96]),
      .rsp_status         (status),
      .rsp_found          (found),
      .rsp_popped_id      (popped_id),
      .rsp_popped_time    (popped_time),
      .rsp_popped_flags   (popped_flags),
      .rsp_entry_count    (entry_count)
   );

   assign rsp_tdata = {entry_count, popped_flags, popped_time, popped_id, found, status};

endmodule
`default_nettype wire

// ===== dv/tb_unique_id_move_to_front_stack_top.sv =====
`default_nettype none
module tb_unique_id_move_to_front_stack_top;
   timeunit 1ns;
   timeprecision 1ps;

   import uimtf_pkg::*;

   // modes with no operation behind them
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
   localparam int         ID_POOL_SIZE     = 20;
   localparam int         PHASES           = 4;
   localparam int         RANDOM_PER_PHASE = 412;

   typedef struct {
      logic [2:0]  mode;
      logic [31:0] region_id;
      logic [63:0] enter_time;
      logic [2:0]  paradigm_index;
   } stack_op_type;

   typedef struct {
      logic [1:0]  status;
      logic        found;
      logic [31:0] popped_id;
      logic [63:0] popped_time;
      logic [7:0]  popped_flags;
      logic [4:0]  entry_count;
   } stack_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;  // region_id, enter_time, paradigm_index, zero pad
   logic [2:0]   req_tuser = '0;  // mode
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;       // status, found, popped_id, popped_time,
                                  // popped_flags, entry_count

   unique_id_move_to_front_stack_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // shadow copy of the stack; cell 0 is the bottom
   logic [31:0] shadow_ids   [DEPTH];
   logic [63:0] shadow_times [DEPTH];
   flag_type    shadow_flags [DEPTH];
   int          shadow_fill = 0;

   stack_op_type  pending_ops[$];
   stack_rsp_type expected_rsps[$];
   logic [31:0]   id_pool[ID_POOL_SIZE];

   int  queued_count   = 0;
   int  accepted_count = 0;
   int  error_count    = 0;
   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   int  pop_hits       = 0;
   int  full_refusals  = 0;
   int  find_hits      = 0;
   int  move_hits      = 0;
   int  full_visits    = 0;
   bit  req_fire       = 1'b0;

   int idle_send[PHASES] = '{0, 63, 0, 11};
   int idle_recv[PHASES] = '{0, 0, 63, 11};

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int locate_id(logic [31:0] id);
      for (int i = 0; i < shadow_fill; i++) begin
         if (shadow_ids[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic stack_rsp_type apply_stack_op(stack_op_type op);
      stack_rsp_type r;
      int            pos;
      flag_type      keep;
      r.status = STATUS_OK;
      r.found = 1'b0;
      r.popped_id = '0;
      r.popped_time = '0;
      r.popped_flags = '0;
      case (op.mode)
         MODE_FIND: begin
            r.found = (locate_id(op.region_id) >= 0);
            if (r.found) find_hits++;
         end
         MODE_PUSH: begin
            pos = locate_id(op.region_id);
            if (pos >= 0) begin
               // present id: slide the cells above it down, put it on top
               keep = shadow_flags[pos];
               for (int i = pos; i + 1 < shadow_fill; i++) begin
                  shadow_ids[i]   = shadow_ids[i + 1];
                  shadow_times[i] = shadow_times[i + 1];
                  shadow_flags[i] = shadow_flags[i + 1];
               end
               shadow_ids[shadow_fill - 1]   = op.region_id;
               shadow_times[shadow_fill - 1] = op.enter_time;
               shadow_flags[shadow_fill - 1] = keep;
               move_hits++;
            end else if (shadow_fill >= DEPTH) begin
               r.status = STATUS_FULL;
               full_refusals++;
            end else begin
               shadow_ids[shadow_fill]   = op.region_id;
               shadow_times[shadow_fill] = op.enter_time;
               shadow_flags[shadow_fill] = '0;
               shadow_fill++;
               if (shadow_fill == DEPTH) full_visits++;
            end
         end
         MODE_POP: begin
            if (shadow_fill == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               shadow_fill--;
               r.popped_id    = shadow_ids[shadow_fill];
               r.popped_time  = shadow_times[shadow_fill];
               r.popped_flags = shadow_flags[shadow_fill];
               pop_hits++;
            end
         end
         MODE_CLEAR: begin
            shadow_fill = 0;
         end
         MODE_MARK: begin
            if (op.paradigm_index < PARADIGMS) begin
               for (int i = 0; i < shadow_fill; i++) begin
                  shadow_flags[i][op.paradigm_index] = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      r.entry_count = shadow_fill[4:0];
      return r;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
         error_count++;
      end
   endfunction

   task automatic add_op(logic [2:0] mode, logic [31:0] id, logic [63:0] t, logic [2:0] pidx);
      stack_op_type op;
      op.mode = mode;
      op.region_id = id;
      op.enter_time = t;
      op.paradigm_index = pidx;
      pending_ops.push_back(op);
      queued_count++;
   endtask

   task automatic add_random_op(bit filling);
      int          pick;
      logic [2:0]  mode;
      logic [31:0] id;
      pick = $urandom_range(99);
      if (filling) begin
         if (pick < 60) mode = MODE_PUSH;
         else if (pick < 75) mode = MODE_FIND;
         else if (pick < 83) mode = MODE_POP;
         else if (pick < 93) mode = MODE_MARK;
         else if (pick < 94) mode = MODE_CLEAR;
         else mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      end else begin
         if (pick < 25) mode = MODE_PUSH;
         else if (pick < 45) mode = MODE_FIND;
         else if (pick < 85) mode = MODE_POP;
         else if (pick < 92) mode = MODE_MARK;
         else if (pick < 94) mode = MODE_CLEAR;
         else mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      end
      // mostly a small pool of ids so pushes hit present entries
      if ($urandom_range(99) < 85) id = id_pool[$urandom_range(ID_POOL_SIZE - 1)];
      else id = $urandom;
      add_op(mode, id, {$urandom, $urandom}, 3'($urandom_range(7)));
   endtask

   task automatic load_random(int count);
      int left;
      int burst;
      bit filling;
      left = count;
      while (left > 0) begin
         // bursts that lean toward filling or draining the stack
         burst = $urandom_range(10, 40);
         filling = $urandom_range(1);
         for (int k = 0; k < burst && left > 0; k++) begin
            add_random_op(filling);
            left--;
         end
      end
   endtask

   task automatic load_directed();
      add_op(MODE_POP, '0, '0, '0);
      add_op(MODE_FIND, '0, '0, '0);
      add_op(MODE_PUSH, '0, '0, '0);
      add_op(MODE_PUSH, '1, '1, '1);
      add_op(MODE_FIND, '0, '1, '0);
      add_op(MODE_FIND, '1, '0, '1);
      add_op(MODE_MARK, '0, '0, 3'd0);
      add_op(MODE_MARK, '1, '1, 3'd7);
      // id directly below the top still moves to the top
      add_op(MODE_PUSH, '0, 64'h0123_4567_89ab_cdef, '0);
      for (int k = 0; k < DEPTH - 2; k++) begin
         add_op(MODE_PUSH, 32'h1000_0000 + k, {$urandom, $urandom}, '0);
      end
      add_op(MODE_PUSH, 32'h2000_0000, {$urandom, $urandom}, '0);  // new id on full
      add_op(MODE_PUSH, '1, 64'hfedc_ba98_7654_3210, '0);          // present id on full
      add_op(MODE_MARK, '0, '0, 3'd3);
      add_op(MODE_POP, '0, '0, '0);
      add_op(MODE_SPARE_FIRST, '1, '1, '1);
      add_op(MODE_SPARE_FIRST + 3'd1, '0, '0, '0);
      add_op(MODE_SPARE_LAST, '1, '1, '1);
      add_op(MODE_CLEAR, '1, '1, '1);
      add_op(MODE_POP, '0, '0, '0);
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      stack_op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fire) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               op = pending_ops.pop_front();
               req_tdata  <= {5'b0, op.paradigm_index, op.enter_time, op.region_id};
               req_tuser  <= op.mode;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor and predictor: sample on the rising edge
   always @(posedge clock) begin
      stack_rsp_type want;
      stack_op_type  op;
      req_fire = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: result with no item outstanding, actual %h", $realtime, rsp_tdata);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("status",       64'(want.status),       64'(rsp_tdata[1:0]));
               check_field("found",        64'(want.found),        64'(rsp_tdata[2]));
               check_field("popped_id",    64'(want.popped_id),    64'(rsp_tdata[34:3]));
               check_field("popped_time",  want.popped_time,       rsp_tdata[98:35]);
               check_field("popped_flags", 64'(want.popped_flags), 64'(rsp_tdata[106:99]));
               check_field("entry_count",  64'(want.entry_count),  64'(rsp_tdata[111:107]));
            end
         end
         if (req_tvalid && req_tready) begin
            req_fire = 1'b1;
            op.mode = req_tuser;
            op.region_id = req_tdata[31:0];
            op.enter_time = req_tdata[95:32];
            op.paradigm_index = req_tdata[98:96];
            expected_rsps.push_back(apply_stack_op(op));
            accepted_count++;
         end
      end
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int k = 2; k < ID_POOL_SIZE; k++) id_pool[k] = $urandom;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < PHASES; phase++) begin
         send_idle_pct = idle_send[phase];
         recv_stall_pct = idle_recv[phase];
         if (phase == 0) load_directed();
         load_random(RANDOM_PER_PHASE);
         while (accepted_count != queued_count || expected_rsps.size() != 0) begin
            @(negedge clock);
         end
      end
      repeat (10) @(negedge clock);
      $display("ran %0d items over %0d idle/stall phases, %0d results still outstanding",
               accepted_count, PHASES, expected_rsps.size());
      $display("pops %0d, full refusals %0d, moves to top %0d, find hits %0d, full %0d times",
               pop_hits, full_refusals, move_hits, find_hits, full_visits);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire
